FILE: rtl/uint128_mul_div_mod_unit_top_defines.svh
// Assertion macros shared by the 128-bit multiply/divide unit RTL.
`ifndef UINT128_MUL_DIV_MOD_UNIT_TOP_DEFINES_SVH
`define UINT128_MUL_DIV_MOD_UNIT_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Clocked property, disabled while reset is asserted.
`define UIM_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("uim assertion failed");

// Same-cycle implication from a condition to a consequence.
`define UIM_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("uim implication failed");

`else

`define UIM_ASSERT(label, prop)
`define UIM_ASSERT_IMPL(label, ante, cons)

`endif

`endif

FILE: rtl/uim_pkg.sv
// Shared constants and types for the 128-bit multiply/divide unit.
package uim_pkg;

	localparam int WORD_W = 64;
	localparam int OPND_W = 2 * WORD_W;
	localparam int CNT_W  = $clog2(OPND_W);
	localparam int OP_W   = 2;

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OPND_W - 1);

	localparam logic [OP_W-1:0] OP_MUL = 2'd0;
	localparam logic [OP_W-1:0] OP_DIV = 2'd1;
	localparam logic [OP_W-1:0] OP_MOD = 2'd2;

	typedef struct packed {
		logic [WORD_W-1:0] result_hi;
		logic [WORD_W-1:0] result_lo;
		logic              div_by_zero;
	} res_t;

endpackage

FILE: rtl/uint128_mul_div_mod_unit_top.sv
// Unsigned 128-bit multiply / divide / modulo unit, top level.
//
// Requests arrive on the s_axis channel: tuser carries the operation (0 multiply,
// 1 divide, 2 modulo), tdata the two 128-bit operands as 64-bit words. Each request
// gives one result on m_axis: tdata holds the 128-bit result, tuser the
// divide-by-zero flag. Multiply wraps modulo 2^128; divide truncates; modulo gives
// the remainder. A zero divisor returns zero with the flag set; code 3 returns zero.
//
// One request is worked at a time. The bit-serial engine runs its shift-add or
// restore-subtract loop over all 128 operand bits, one operand bit per cycle, and then
// hands the result to the output register that drives m_axis; a zero divisor or unused
// code skips the loop. The engine takes no new request until its result has moved
// into the output register.
//
// Reset clears the engine and the output register; s_axis_tready is high from reset on.
// When the receiver stalls, the finished result waits in the output register and the
// engine takes the next request; a second result then waits in the engine, and
// s_axis_tready stays low until the output register drains.
module uint128_mul_div_mod_unit_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// left_hi [63:0], left_lo [127:64], right_hi [191:128], right_lo [255:192]
	input  logic [255:0] s_axis_tdata,
	// op [1:0]
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// result_hi [63:0], result_lo [127:64]
	output logic [127:0] m_axis_tdata,
	// div_by_zero [0]
	output logic         m_axis_tuser
);
	import uim_pkg::*;

	logic [OPND_W-1:0] left;
	logic [OPND_W-1:0] right;
	logic              core_valid;
	logic              core_ready;
	res_t              core_res;
	res_t              out_res;

	assign left  = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
	assign right = {s_axis_tdata[191:128], s_axis_tdata[255:192]};

	uim_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.op        (s_axis_tuser),
		.left      (left),
		.right     (right),
		.out_valid (core_valid),
		.out_ready (core_ready),
		.out_res   (core_res)
	);

	uim_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (core_valid),
		.in_ready  (core_ready),
		.in_res    (core_res),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tdata = {out_res.result_lo, out_res.result_hi};
	assign m_axis_tuser = out_res.div_by_zero;

endmodule

FILE: rtl/uim_core.sv
// Bit-serial engine: shift-add multiply and restoring divide, one bit per cycle.
`include "uint128_mul_div_mod_unit_top_defines.svh"

module uim_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [uim_pkg::OP_W-1:0]     op,
	input  logic [uim_pkg::OPND_W-1:0]   left,
	input  logic [uim_pkg::OPND_W-1:0]   right,
	output logic                         out_valid,
	input  logic                         out_ready,
	output uim_pkg::res_t                out_res
);
	import uim_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [OP_W-1:0]     op_q;
	logic [OPND_W-1:0]   x_q;
	logic [OPND_W-1:0]   y_q;
	logic [OPND_W-1:0]   acc_q;
	logic                dz_q;

	logic [OPND_W:0]     rem_sh;
	logic [OPND_W+1:0]   diff;
	logic                fits;
	logic [OPND_W-1:0]   mul_sum;
	logic                right_zero;
	logic                op_div;
	logic [OPND_W-1:0]   res_sel;

	assign rem_sh     = {acc_q, x_q[OPND_W-1]};
	assign diff       = {1'b0, rem_sh} - {2'b00, y_q};
	assign fits       = !diff[OPND_W+1];
	assign mul_sum    = acc_q + x_q;
	assign right_zero = (right == '0);
	assign op_div     = (op == OP_DIV) || (op == OP_MOD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			op_q    <= OP_MUL;
			x_q     <= '0;
			y_q     <= '0;
			acc_q   <= '0;
			dz_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q  <= op;
						y_q   <= right;
						acc_q <= '0;
						cnt_q <= '0;
						dz_q  <= op_div && right_zero;
						if ((op == OP_MUL) || (op_div && !right_zero)) begin
							x_q     <= left;
							state_q <= ST_RUN;
						end else begin
							// zero divisor or unused code: zero result
							x_q     <= '0;
							state_q <= ST_DONE;
						end
					end
				end
				ST_RUN: begin
					if (op_q == OP_MUL) begin
						if (y_q[0]) begin
							acc_q <= mul_sum;
						end
						x_q <= {x_q[OPND_W-2:0], 1'b0};
						y_q <= {1'b0, y_q[OPND_W-1:1]};
					end else begin
						// quotient bits shift into x as dividend bits shift out
						acc_q <= fits ? diff[OPND_W-1:0] : rem_sh[OPND_W-1:0];
						x_q   <= {x_q[OPND_W-2:0], fits};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		case (op_q)
			OP_MUL:  res_sel = acc_q;
			OP_DIV:  res_sel = x_q;
			OP_MOD:  res_sel = acc_q;
			default: res_sel = '0;
		endcase
	end

	assign in_ready            = (state_q == ST_IDLE);
	assign out_valid           = (state_q == ST_DONE);
	assign out_res.result_hi   = res_sel[OPND_W-1:WORD_W];
	assign out_res.result_lo   = res_sel[WORD_W-1:0];
	assign out_res.div_by_zero = dz_q;

	`UIM_ASSERT(a_cnt_adv, (state_q == ST_RUN && cnt_q != CNT_LAST) |=> (state_q == ST_RUN && cnt_q == $past(cnt_q) + 1'b1))
	`UIM_ASSERT(a_res_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_res)))
	`UIM_ASSERT_IMPL(a_dz_zero, out_valid && out_res.div_by_zero, out_res.result_hi == '0 && out_res.result_lo == '0)
	`UIM_ASSERT_IMPL(a_mul_no_dz, state_q != ST_IDLE && op_q == OP_MUL, !dz_q)

endmodule

FILE: rtl/uim_out_reg.sv
// Output register that holds one finished result until the receiver takes it.
`include "uint128_mul_div_mod_unit_top_defines.svh"

module uim_out_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  uim_pkg::res_t in_res,
	output logic          out_valid,
	input  logic          out_ready,
	output uim_pkg::res_t out_res
);
	import uim_pkg::*;

	logic valid_q;
	res_t res_q;

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			res_q   <= '0;
		end else begin
			if (in_ready) begin
				valid_q <= in_valid;
				if (in_valid) begin
					res_q <= in_res;
				end
			end
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;

	`UIM_ASSERT(a_load_when_free, (in_valid && in_ready) |=> (valid_q && res_q == $past(in_res)))

endmodule

FILE: test/uint128_mul_div_mod_unit_checker.sv
// Checker for the 128-bit multiply/divide unit: predicts each result and compares it.
module uint128_mul_div_mod_unit_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	// left_hi [63:0], left_lo [127:64], right_hi [191:128], right_lo [255:192]
	input  logic [255:0] s_axis_tdata,
	// op [1:0]
	input  logic [1:0]   s_axis_tuser,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// result_hi [63:0], result_lo [127:64]
	input  logic [127:0] m_axis_tdata,
	// div_by_zero [0]
	input  logic         m_axis_tuser,
	output int           mismatch_count,
	output int           pending_results
);
	timeunit 1ns;
	timeprecision 1ps;

	import uim_pkg::*;

	res_t expected_results[$];

	function automatic res_t compute_result(logic [OP_W-1:0] op, logic [OPND_W-1:0] left,
			logic [OPND_W-1:0] right);
		res_t             outcome;
		logic [OPND_W-1:0] value;
		value = '0;
		outcome.div_by_zero = 1'b0;
		case (op) inside
			OP_MUL: begin
				// wrap to 128 bits
				value = left * right;
			end
			OP_DIV, OP_MOD: begin
				if (right == '0) begin
					outcome.div_by_zero = 1'b1;
				end else if (op == OP_DIV) begin
					value = left / right;
				end else begin
					value = left % right;
				end
			end
			default: begin
				value = '0;
			end
		endcase
		outcome.result_hi = value[OPND_W-1:WORD_W];
		outcome.result_lo = value[WORD_W-1:0];
		return outcome;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		res_t got;
		int   errors;
		if (!arst_n) begin
			expected_results.delete();
			pending_results <= 0;
		end else begin
			errors = 0;
			if (s_axis_tvalid && s_axis_tready) begin
				expected_results.push_back(compute_result(s_axis_tuser,
					{s_axis_tdata[63:0], s_axis_tdata[127:64]},
					{s_axis_tdata[191:128], s_axis_tdata[255:192]}));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.result_hi   = m_axis_tdata[63:0];
				got.result_lo   = m_axis_tdata[127:64];
				got.div_by_zero = m_axis_tuser;
				if (expected_results.size() == 0) begin
					$error("unexpected result: result_hi %h result_lo %h div_by_zero %b",
						got.result_hi, got.result_lo, got.div_by_zero);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (got.result_hi !== want.result_hi) begin
						$error("result_hi: expected %h, actual %h", want.result_hi,
							got.result_hi);
						errors++;
					end
					if (got.result_lo !== want.result_lo) begin
						$error("result_lo: expected %h, actual %h", want.result_lo,
							got.result_lo);
						errors++;
					end
					if (got.div_by_zero !== want.div_by_zero) begin
						$error("div_by_zero: expected %b, actual %b", want.div_by_zero,
							got.div_by_zero);
						errors++;
					end
				end
			end
			if (errors != 0) begin
				mismatch_count <= mismatch_count + 1;
			end
			pending_results <= expected_results.size();
		end
	end

endmodule

FILE: test/tb_uint128_mul_div_mod_unit_top.sv
// Stimulus and verdict for the 128-bit multiply/divide unit.
module tb_uint128_mul_div_mod_unit_top;
	timeunit 1ns;
	timeprecision 1ps;

	import uim_pkg::*;

	localparam logic [OP_W-1:0]   OP_RESERVED    = 2'd3;
	localparam logic [OPND_W-1:0] ALL_ONES       = '1;
	localparam logic [OPND_W-1:0] WORD_ONES      = {{WORD_W{1'b0}}, {WORD_W{1'b1}}};
	localparam int                ITEMS_PER_PHASE = 350;
	localparam int                WATCHDOG_LIMIT = 4000;
	localparam int                DRAIN_CYCLES   = 8;

	logic         clk;
	logic         arst_n        = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	// left_hi [63:0], left_lo [127:64], right_hi [191:128], right_lo [255:192]
	logic [255:0] s_axis_tdata  = '0;
	// op [1:0]
	logic [1:0]   s_axis_tuser  = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	// result_hi [63:0], result_lo [127:64]
	logic [127:0] m_axis_tdata;
	// div_by_zero [0]
	logic         m_axis_tuser;

	int mismatch_count;
	int pending_results;
	int sender_idle_pct    = 0;
	int receiver_stall_pct = 0;
	int quiet_cycles       = 0;

	uint128_mul_div_mod_unit_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	uint128_mul_div_mod_unit_checker result_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tuser    (s_axis_tuser),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tuser    (m_axis_tuser),
		.mismatch_count  (mismatch_count),
		.pending_results (pending_results)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// End the run when nothing moves on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_request(logic [OP_W-1:0] op, logic [OPND_W-1:0] left,
			logic [OPND_W-1:0] right);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {right[WORD_W-1:0], right[OPND_W-1:WORD_W],
			left[WORD_W-1:0], left[OPND_W-1:WORD_W]};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	function automatic logic [OPND_W-1:0] random_operand();
		logic [OPND_W-1:0] value;
		int unsigned       bits;
		value = {$urandom, $urandom, $urandom, $urandom};
		case ($urandom_range(11)) inside
			0: value = '0;
			1: value = ALL_ONES;
			2: value = {{(OPND_W-1){1'b0}}, 1'b1} << $urandom_range(OPND_W - 1);
			[3:6]: begin
				// vary the bit length so quotients of every size occur
				bits  = $urandom_range(OPND_W, 1);
				value = value >> (OPND_W - bits);
			end
			default: ;
		endcase
		return value;
	endfunction

	task automatic send_random_request();
		logic [OP_W-1:0]   op;
		logic [OPND_W-1:0] left;
		logic [OPND_W-1:0] right;
		int unsigned       pick;
		pick = $urandom_range(15);
		if (pick < 5) begin
			op = OP_MUL;
		end else if (pick < 10) begin
			op = OP_DIV;
		end else if (pick < 15) begin
			op = OP_MOD;
		end else begin
			op = OP_RESERVED;
		end
		left  = random_operand();
		right = random_operand();
		// keep the divisor close to the dividend now and then
		if (op != OP_MUL && $urandom_range(3) == 0) begin
			right = (left >> $urandom_range(6)) + OPND_W'($urandom_range(2));
		end
		send_request(op, left, right);
	endtask

	task automatic run_phase(int idle_pct, int stall_pct);
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
		repeat (ITEMS_PER_PHASE) send_random_request();
	endtask

	initial begin
		logic [OPND_W-1:0] mixed;
		mixed = {$urandom, $urandom, $urandom, $urandom};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_request(OP_MUL, ALL_ONES, ALL_ONES);
		send_request(OP_MUL, '0, ALL_ONES);
		send_request(OP_MUL, WORD_ONES, WORD_ONES);
		send_request(OP_MUL, ALL_ONES << (OPND_W - 1), 128'd2);
		send_request(OP_MUL, mixed, 128'd1);
		send_request(OP_DIV, mixed, '0);
		send_request(OP_MOD, ALL_ONES, '0);
		send_request(OP_DIV, '0, '0);
		send_request(OP_DIV, ALL_ONES, 128'd1);
		send_request(OP_DIV, ALL_ONES, ALL_ONES);
		send_request(OP_MOD, ALL_ONES, ALL_ONES);
		send_request(OP_DIV, 128'd5, 128'd1 << 100);
		send_request(OP_MOD, 128'd5, 128'd1 << 100);
		send_request(OP_DIV, ALL_ONES, 128'd1 << (OPND_W - 1));
		send_request(OP_MOD, ALL_ONES, ~WORD_ONES);
		send_request(OP_DIV, mixed, ~WORD_ONES & {$urandom, $urandom, 64'd0});
		send_request(OP_MOD, (128'd1 << (OPND_W - 1)) + 128'd7, 128'd3);
		send_request(OP_MOD, ALL_ONES, (128'd1 << (OPND_W - 1)) + 128'd1);
		send_request(OP_DIV, ALL_ONES - 128'd1, ALL_ONES);
		send_request(OP_RESERVED, ALL_ONES, ALL_ONES);
		send_request(OP_RESERVED, '0, '0);

		run_phase(0, 0);
		run_phase(74, 0);
		run_phase(0, 74);
		run_phase(15, 15);
		s_axis_tvalid <= 1'b0;

		while (pending_results != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
